// ===== hw/rtl/pdwr_pkg.sv =====
`default_nettype none

package pdwr_pkg;

    localparam int COORD_W = 29;
    localparam int RAD_W   = 30;
    localparam int DIST_W  = 30;
    localparam int SQ_W    = 2 * DIST_W;
    localparam int REM_W   = DIST_W + 1;
    localparam int TRIAL_W = DIST_W + 3;
    localparam int CELLS   = DIST_W;

    localparam int S_DATA_W = 152;
    localparam int M_DATA_W = 32;
    localparam int M_USER_W = 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [COORD_W-1:0]        t_diff;
    typedef logic [RAD_W-1:0]          t_rad;
    typedef logic [SQ_W-1:0]           t_sq;
    typedef logic [DIST_W-1:0]         t_dist;

    typedef struct packed {
        logic              in_radius;
        t_sq               sq;
        logic [REM_W-1:0]  rem;
        t_dist             root;
    } t_cell;

endpackage

`default_nettype wire

// ===== hw/rtl/planar_distance_within_radius_top.sv =====
// Planar radius check: squared distance of two points against a squared radius.
// Slave channel (s_axis): one item per point pair, tdata packs first_x,
// first_y, second_x, second_y (29-bit signed each) and search_radius
// (30-bit unsigned). Master channel (m_axis): one item per input item,
// tuser carries inside_res and tdata carries distance_dm (floor of the root
// when inside, zero when outside).
// Throughput: one item per cycle while s_axis_tready stays high.
// An accepted item passes through 34 register stages: three front stages
// (difference, squares, sum and compare), thirty square-root cells that each
// settle one root bit, and the output register; the accepting edge loads
// the first stage, and m_axis_tvalid rises when the output register takes it.
// Reset (synchronous, active low) empties every stage; no result is shown
// until an item is accepted after reset.
// When the receiver stalls, the output register holds its item and the next
// item to leave the pipeline lands in a skid register; s_axis_tready then drops
// and the whole pipeline holds until the skid register drains.
`default_nettype none

module planar_distance_within_radius_top (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // [28:0] first_x, [57:29] first_y, [86:58] second_x, [115:87] second_y,
    // [145:116] search_radius, [151:146] zero
    input  wire  [pdwr_pkg::S_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // [29:0] distance_dm, [31:30] zero
    output logic [pdwr_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // [0] inside_res
    output logic [pdwr_pkg::M_USER_W-1:0]   m_axis_tuser
);

    localparam int C = pdwr_pkg::COORD_W;

    logic                    w_ce;
    logic                    w_v   [0:pdwr_pkg::CELLS];
    pdwr_pkg::t_cell         w_c   [0:pdwr_pkg::CELLS];
    logic                    w_last_v;
    logic                    w_last_in;
    pdwr_pkg::t_dist         w_last_dist;

    logic                    r_out_valid;
    logic                    r_out_inside;
    pdwr_pkg::t_dist         r_out_dist;
    logic                    r_skid_valid;
    logic                    r_skid_inside;
    pdwr_pkg::t_dist         r_skid_dist;

    assign w_ce          = !r_skid_valid;
    assign s_axis_tready = w_ce;

    pdwr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ce            (w_ce),
        .i_valid         (s_axis_tvalid),
        .i_first_x       (s_axis_tdata[C-1:0]),
        .i_first_y       (s_axis_tdata[2*C-1:C]),
        .i_second_x      (s_axis_tdata[3*C-1:2*C]),
        .i_second_y      (s_axis_tdata[4*C-1:3*C]),
        .i_search_radius (s_axis_tdata[4*C+pdwr_pkg::RAD_W-1:4*C]),
        .o_valid         (w_v[0]),
        .o_cell          (w_c[0])
    );

    for (genvar g = 0; g < pdwr_pkg::CELLS; g++) begin : g_cell
        pdwr_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_valid (w_v[g]),
            .i_cell  (w_c[g]),
            .o_valid (w_v[g+1]),
            .o_cell  (w_c[g+1])
        );
    end

    assign w_last_v    = w_v[pdwr_pkg::CELLS];
    assign w_last_in   = w_c[pdwr_pkg::CELLS].in_radius;
    assign w_last_dist = w_last_in ? w_c[pdwr_pkg::CELLS].root : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_inside <= r_skid_inside;
                r_out_dist   <= r_skid_dist;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid  <= w_last_v;
            r_out_inside <= w_last_in;
            r_out_dist   <= w_last_dist;
        end else if (w_last_v) begin
            r_skid_valid  <= 1'b1;
            r_skid_inside <= w_last_in;
            r_skid_dist   <= w_last_dist;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = pdwr_pkg::M_DATA_W'(r_out_dist);
    assign m_axis_tuser  = r_out_inside;

endmodule

`default_nettype wire

// ===== hw/rtl/pdwr_front.sv =====
`default_nettype none

module pdwr_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_ce,
    input  wire               i_valid,
    input  pdwr_pkg::t_coord  i_first_x,
    input  pdwr_pkg::t_coord  i_first_y,
    input  pdwr_pkg::t_coord  i_second_x,
    input  pdwr_pkg::t_coord  i_second_y,
    input  pdwr_pkg::t_rad    i_search_radius,
    output logic              o_valid,
    output pdwr_pkg::t_cell   o_cell
);

    logic                        r_va;
    logic                        r_vb;
    logic                        r_vc;
    pdwr_pkg::t_diff             r_dx;
    pdwr_pkg::t_diff             r_dy;
    pdwr_pkg::t_rad              r_rad;
    logic [2*pdwr_pkg::COORD_W-1:0] r_dx2;
    logic [2*pdwr_pkg::COORD_W-1:0] r_dy2;
    pdwr_pkg::t_sq               r_rr;
    pdwr_pkg::t_cell             r_cell;

    logic [pdwr_pkg::COORD_W:0]  n_dxs;
    logic [pdwr_pkg::COORD_W:0]  n_dys;
    logic [pdwr_pkg::COORD_W:0]  n_dxa;
    logic [pdwr_pkg::COORD_W:0]  n_dya;
    pdwr_pkg::t_sq               n_dd;

    always_comb begin
        n_dxs = {i_first_x[pdwr_pkg::COORD_W-1], i_first_x}
              - {i_second_x[pdwr_pkg::COORD_W-1], i_second_x};
        n_dys = {i_first_y[pdwr_pkg::COORD_W-1], i_first_y}
              - {i_second_y[pdwr_pkg::COORD_W-1], i_second_y};
        n_dxa = n_dxs[pdwr_pkg::COORD_W] ? ((pdwr_pkg::COORD_W+1)'(0) - n_dxs) : n_dxs;
        n_dya = n_dys[pdwr_pkg::COORD_W] ? ((pdwr_pkg::COORD_W+1)'(0) - n_dys) : n_dys;
        n_dd  = pdwr_pkg::SQ_W'(r_dx2) + pdwr_pkg::SQ_W'(r_dy2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_ce) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_dx  <= n_dxa[pdwr_pkg::COORD_W-1:0];
            r_dy  <= n_dya[pdwr_pkg::COORD_W-1:0];
            r_rad <= i_search_radius;
            r_dx2 <= (2*pdwr_pkg::COORD_W)'(r_dx) * (2*pdwr_pkg::COORD_W)'(r_dx);
            r_dy2 <= (2*pdwr_pkg::COORD_W)'(r_dy) * (2*pdwr_pkg::COORD_W)'(r_dy);
            r_rr  <= pdwr_pkg::SQ_W'(r_rad) * pdwr_pkg::SQ_W'(r_rad);
            r_cell.in_radius <= (n_dd <= r_rr);
            r_cell.sq        <= n_dd;
            r_cell.rem       <= '0;
            r_cell.root      <= '0;
        end
    end

    assign o_valid = r_vc;
    assign o_cell  = r_cell;

endmodule

`default_nettype wire

// ===== hw/rtl/pdwr_sqrt_cell.sv =====
`default_nettype none

module pdwr_sqrt_cell (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_ce,
    input  wire              i_valid,
    input  pdwr_pkg::t_cell  i_cell,
    output logic             o_valid,
    output pdwr_pkg::t_cell  o_cell
);

    logic                          r_valid;
    pdwr_pkg::t_cell               r_cell;
    logic [pdwr_pkg::TRIAL_W-1:0]  n_part;
    logic [pdwr_pkg::TRIAL_W-1:0]  n_trial;
    logic [pdwr_pkg::TRIAL_W-1:0]  n_diff;
    logic                          n_ge;
    pdwr_pkg::t_cell               n_cell;

    always_comb begin
        n_part  = {i_cell.rem, i_cell.sq[pdwr_pkg::SQ_W-1 -: 2]};
        n_trial = {1'b0, i_cell.root, 2'b01};
        n_ge    = (n_part >= n_trial);
        n_diff  = n_part - n_trial;
        n_cell.in_radius = i_cell.in_radius;
        n_cell.sq     = {i_cell.sq[pdwr_pkg::SQ_W-3:0], 2'b00};
        n_cell.rem    = n_ge ? n_diff[pdwr_pkg::REM_W-1:0] : n_part[pdwr_pkg::REM_W-1:0];
        n_cell.root   = {i_cell.root[pdwr_pkg::DIST_W-2:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

`default_nettype wire

// ===== hw/rtl/pdwr_checker.sv =====
`default_nettype none

module pdwr_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           s_axis_tready,
    input wire                           m_axis_tvalid,
    input wire                           m_axis_tready,
    input wire [pdwr_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input wire [pdwr_pkg::M_USER_W-1:0]  m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled item changed");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("outside item with nonzero distance");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("item shown right after reset");

    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input ready dropped without output stall");

endmodule

bind planar_distance_within_radius_top pdwr_checker u_pdwr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int          LATENCY     = 34;
    localparam longint      CYCLE_LIMIT = 600000;
    localparam int          MERC_MAX    = 200375084;
    localparam int          RANDOM_CNT  = 1530;

    typedef struct {
        pdwr_pkg::t_coord ax;
        pdwr_pkg::t_coord ay;
        pdwr_pkg::t_coord bx;
        pdwr_pkg::t_coord by;
        pdwr_pkg::t_rad   rad;
        bit               hold_for_drain;
    } t_point_pair;

    typedef struct {
        bit              in_radius;
        pdwr_pkg::t_dist dist_dm;
    } t_radius_verdict;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // [28:0] first_x, [57:29] first_y, [86:58] second_x, [115:87] second_y,
    // [145:116] search_radius, [151:146] zero
    logic [pdwr_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [29:0] distance_dm, [31:30] zero
    logic [pdwr_pkg::M_DATA_W-1:0]   m_axis_tdata;
    // [0] inside_res
    logic [pdwr_pkg::M_USER_W-1:0]   m_axis_tuser;

    t_point_pair     pending_pairs[$];
    t_radius_verdict verdict_q[$];
    t_point_pair     on_bus;
    longint          n_cycles = 0;
    int              n_errors = 0;
    int              n_accepted = 0;
    int              n_checked = 0;
    int              n_inside = 0;
    int              n_on_edge = 0;
    int              src_gap = 0;
    int              sink_stall = 0;

    planar_distance_within_radius_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic longint unsigned dist_squared(t_point_pair p);
        longint signed   dxs;
        longint signed   dys;
        longint unsigned dx;
        longint unsigned dy;
        dxs = longint'(p.ax) - longint'(p.bx);
        dys = longint'(p.ay) - longint'(p.by);
        dx  = (dxs < 0) ? longint'(-dxs) : longint'(dxs);
        dy  = (dys < 0) ? longint'(-dys) : longint'(dys);
        return dx * dx + dy * dy;
    endfunction

    function automatic t_radius_verdict judge_pair(t_point_pair p);
        t_radius_verdict v;
        longint unsigned dd;
        longint unsigned rr;
        dd = dist_squared(p);
        rr = longint'(p.rad) * longint'(p.rad);
        v.in_radius = (dd <= rr);
        v.dist_dm   = v.in_radius ? pdwr_pkg::t_dist'(floor_root(dd)) : '0;
        return v;
    endfunction

    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic pdwr_pkg::t_coord merc_coord();
        return pdwr_pkg::t_coord'(int'($urandom_range(0, 2 * MERC_MAX)) - MERC_MAX);
    endfunction

    function automatic t_point_pair make_pair(int ax, int ay, int bx, int by, int unsigned rad);
        t_point_pair p;
        p.ax = pdwr_pkg::t_coord'(ax);
        p.ay = pdwr_pkg::t_coord'(ay);
        p.bx = pdwr_pkg::t_coord'(bx);
        p.by = pdwr_pkg::t_coord'(by);
        p.rad = pdwr_pkg::t_rad'(rad);
        p.hold_for_drain = 1'b0;
        return p;
    endfunction

    function automatic t_point_pair random_pair();
        t_point_pair     p;
        int              span;
        int unsigned     kind;
        longint signed   r0;
        kind = $urandom_range(0, 9);
        p.hold_for_drain = 1'b0;
        if (kind <= 2 || kind == 9) begin
            p.ax = pdwr_pkg::t_coord'($urandom);
            p.ay = pdwr_pkg::t_coord'($urandom);
            p.bx = pdwr_pkg::t_coord'($urandom);
            p.by = pdwr_pkg::t_coord'($urandom);
            p.rad = pdwr_pkg::t_rad'($urandom);
            if (kind == 2) begin
                p.rad = p.rad >> $urandom_range(0, 29);
            end
        end else begin
            span = 1 << $urandom_range(0, 27);
            p.ax = ($urandom_range(0, 3) == 0) ? pdwr_pkg::t_coord'($urandom) : merc_coord();
            p.ay = ($urandom_range(0, 3) == 0) ? pdwr_pkg::t_coord'($urandom) : merc_coord();
            p.bx = p.ax + pdwr_pkg::t_coord'(int'($urandom_range(0, 2 * span)) - span);
            p.by = p.ay + pdwr_pkg::t_coord'(int'($urandom_range(0, 2 * span)) - span);
            if (kind <= 5) begin
                p.rad = pdwr_pkg::t_rad'($urandom_range(0, 3 * span));
            end else begin
                r0 = longint'(floor_root(dist_squared(p))) + $urandom_range(0, 2) - 1;
                p.rad = (r0 < 0) ? '0 : pdwr_pkg::t_rad'(r0);
            end
        end
        return p;
    endfunction

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                verdict_q = {verdict_q, judge_pair(on_bus)};
                n_accepted++;
                if (verdict_q[$].in_radius) n_inside++;
                if (dist_squared(on_bus) == longint'(on_bus.rad) * longint'(on_bus.rad))
                    n_on_edge++;
                if ((n_accepted / 150) % 4 != 2 && $urandom_range(0, 99) < 35)
                    src_gap = idle_len();
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_pairs.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (pending_pairs[0].hold_for_drain && verdict_q.size() != 0) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    on_bus = pending_pairs.pop_front();
                    s_axis_tdata <= {6'b0, on_bus.rad, on_bus.by, on_bus.bx,
                                     on_bus.ay, on_bus.ax};
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // sink side
    always @(posedge i_clk) begin
        t_radius_verdict want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected item: inside_res=%0d distance_dm=%0d",
                           m_axis_tuser[0], m_axis_tdata);
                    n_errors++;
                end else begin
                    want = verdict_q.pop_front();
                    n_checked++;
                    if (m_axis_tuser[0] !== want.in_radius) begin
                        $error("inside_res: expected %0d, got %0d",
                               want.in_radius, m_axis_tuser[0]);
                        n_errors++;
                    end
                    if (m_axis_tdata !== pdwr_pkg::M_DATA_W'(want.dist_dm)) begin
                        $error("distance_dm: expected %0d, got %0d",
                               want.dist_dm, m_axis_tdata);
                        n_errors++;
                    end
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end else if ((n_cycles / 512) % 4 == 1 || $urandom_range(0, 99) < 75) begin
                m_axis_tready <= 1'b1;
            end else begin
                sink_stall = idle_len() - 1;
                m_axis_tready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("planar_distance_within_radius_top test failed");
            $finish;
        end
    end

    initial begin
        t_point_pair p;
        pending_pairs = {pending_pairs, make_pair(0, 0, 0, 0, 0)};
        pending_pairs = {pending_pairs, make_pair(5, -7, 5, -7, 0)};
        pending_pairs = {pending_pairs, make_pair(5, -7, 6, -7, 0)};
        pending_pairs = {pending_pairs, make_pair(0, 0, 3, 4, 5)};
        pending_pairs = {pending_pairs, make_pair(0, 0, 3, 4, 4)};
        pending_pairs = {pending_pairs, make_pair(0, 0, 1, 1, 1)};
        pending_pairs = {pending_pairs, make_pair(0, 0, 1, 1, 2)};
        pending_pairs = {pending_pairs, make_pair(-MERC_MAX, -MERC_MAX, MERC_MAX, MERC_MAX,
                                                  32'h3FFF_FFFF)};
        pending_pairs = {pending_pairs, make_pair(MERC_MAX, -MERC_MAX, -MERC_MAX, MERC_MAX,
                                                  566746324)};
        pending_pairs = {pending_pairs, make_pair(-MERC_MAX, MERC_MAX, MERC_MAX, -MERC_MAX,
                                                  566746325)};
        pending_pairs = {pending_pairs, make_pair(-(1 << 28), -(1 << 28), (1 << 28) - 1,
                                                  (1 << 28) - 1, 32'h3FFF_FFFF)};
        pending_pairs = {pending_pairs, make_pair((1 << 28) - 1, (1 << 28) - 1, -(1 << 28),
                                                  -(1 << 28), 32'h3FFF_FFFF)};
        pending_pairs = {pending_pairs, make_pair(-(1 << 28), -(1 << 28), (1 << 28) - 1,
                                                  (1 << 28) - 1, 0)};
        pending_pairs = {pending_pairs, make_pair((1 << 28) - 1, -(1 << 28), -(1 << 28),
                                                  -(1 << 28), (1 << 29) - 1)};
        pending_pairs = {pending_pairs, make_pair((1 << 28) - 1, -(1 << 28), -(1 << 28),
                                                  -(1 << 28), (1 << 29) - 2)};
        pending_pairs = {pending_pairs, make_pair(-(1 << 28), (1 << 28) - 1, -(1 << 28),
                                                  (1 << 28) - 1, 32'h3FFF_FFFF)};
        pending_pairs = {pending_pairs, make_pair(12345, -67890, -54321, 9876,
                                                  32'h2AAA_AAAA)};
        pending_pairs = {pending_pairs, make_pair(-1, -1, 1, 1, 2)};
        pending_pairs = {pending_pairs, make_pair(-1, -1, 1, 1, 3)};
        for (int i = 0; i < RANDOM_CNT; i++) begin
            p = random_pair();
            p.hold_for_drain = (i == 0 || i == 800);
            pending_pairs = {pending_pairs, p};
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("%0d point pairs checked, %0d inside and %0d outside the radius,",
                 n_checked, n_inside, n_accepted - n_inside);
        $display("%0d exactly on it, with random source gaps and sink stalls", n_on_edge);
        if (n_errors == 0) begin
            $display("planar_distance_within_radius_top test passed");
        end else begin
            $display("planar_distance_within_radius_top test failed");
        end
        $finish;
    end

endmodule
